/* rtl/rpc_pkg.sv */
`default_nettype none

package rpc_pkg;

  // Field and datapath widths
  localparam int DATA_W    = 16;
  localparam int ERR_W     = 17;
  localparam int DIFF_W    = 18;
  localparam int LIMIT_W   = 31;
  localparam int INTEG_W   = 32;
  localparam int ISUM_W    = 33;
  localparam int MUL_A_W   = 17;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = 49;
  localparam int ACC_W     = 64;
  localparam int QUO_W     = DIFF_W + DATA_W;
  localparam int PC_W      = 4;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Datapath operations
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_ERR      = 4'd1;
  localparam logic [3:0] OP_DIFF     = 4'd2;
  localparam logic [3:0] OP_DSTART   = 4'd3;
  localparam logic [3:0] OP_INTSUM   = 4'd4;
  localparam logic [3:0] OP_INTCLAMP = 4'd5;
  localparam logic [3:0] OP_DERIV    = 4'd6;
  localparam logic [3:0] OP_RESULT   = 4'd7;
  localparam logic [3:0] OP_NEXTAX   = 4'd8;
  localparam logic [3:0] OP_DONE     = 4'd9;

  // Multiplier operand selection
  localparam logic [2:0] MUL_NONE     = 3'd0;
  localparam logic [2:0] MUL_ERR_STEP = 3'd1;
  localparam logic [2:0] MUL_KP_ERR   = 3'd2;
  localparam logic [2:0] MUL_KI_INT   = 3'd3;
  localparam logic [2:0] MUL_KD_DER   = 3'd4;

  // Accumulator operations
  localparam logic [2:0] ACC_NONE  = 3'd0;
  localparam logic [2:0] ACC_CLR   = 3'd1;
  localparam logic [2:0] ACC_ADD   = 3'd2;
  localparam logic [2:0] ACC_ADD12 = 3'd3;
  localparam logic [2:0] ACC_NEG   = 3'd4;

  // Jump conditions
  localparam logic [1:0] JMP_NEXT     = 2'd0;
  localparam logic [1:0] JMP_DIV_BUSY = 2'd1;
  localparam logic [1:0] JMP_MORE_AX  = 2'd2;
  localparam logic [1:0] JMP_OUT_FULL = 2'd3;

  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      mul;
    logic [2:0]      acc;
    logic [1:0]      jmp;
    logic [PC_W-1:0] target;
  } rpc_ctrl_t;

  typedef struct packed {
    logic div_busy;
    logic last_axis;
    logic out_full;
  } rpc_stat_t;

endpackage

`default_nettype wire

/* rtl/roll_pitch_pid_compensator.sv */
`default_nettype none

// Channel   Direction  Contents (lowest bits first)
// apb       in/out     register writes and reads, registers at 4*index
// s_axis    in         meas_roll[15:0], meas_pitch[31:16], time_step[47:32]
// m_axis    out        roll_corr[15:0], pitch_corr[31:16]
//
// An item runs the per-axis program once for each axis and then hands off the
// result to the output register; the next input is taken only after the
// sequencer has left its last step. The divider retires two quotient bits a
// cycle; the multiply steps run while it works.
// Synchronous reset clears the sequencer, the integrals, the previous errors
// and the registers. A stalled result is held in the output register while
// the next item is taken; the sequencer waits at its last step only if that
// register is still full.

module roll_pitch_pid_compensator #(
  parameter int NUM_AXES = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rpc_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [rpc_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [rpc_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [47:0]                          s_tdata,  // meas_roll, meas_pitch, time_step
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [31:0]                          m_tdata   // roll_corr, pitch_corr
);
  import rpc_pkg::*;

  localparam logic [2:0] REG_SP_ROLL     = 3'd0;
  localparam logic [2:0] REG_SP_PITCH    = 3'd1;
  localparam logic [2:0] REG_GAIN_PROP   = 3'd2;
  localparam logic [2:0] REG_GAIN_INTEG  = 3'd3;
  localparam logic [2:0] REG_GAIN_DERIV  = 3'd4;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd5;

  logic signed [DATA_W-1:0]  setpoint_roll;
  logic signed [DATA_W-1:0]  setpoint_pitch;
  logic        [DATA_W-1:0]  gain_prop;
  logic        [DATA_W-1:0]  gain_integ;
  logic        [DATA_W-1:0]  gain_deriv;
  logic        [LIMIT_W-1:0] integ_limit;

  logic [2:0]               reg_idx;
  logic                     wr;
  logic                     accept;
  logic                     busy;
  logic                     fire;
  rpc_ctrl_t                ctrl;
  rpc_stat_t                stat;
  logic                     div_busy;
  logic                     last_axis;
  logic signed [DATA_W-1:0] roll_corr;
  logic signed [DATA_W-1:0] pitch_corr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr      = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_roll  <= '0;
      setpoint_pitch <= '0;
      gain_prop      <= '0;
      gain_integ     <= '0;
      gain_deriv     <= '0;
      integ_limit    <= '0;
    end else if (wr) begin
      unique case (reg_idx)
        REG_SP_ROLL:     setpoint_roll  <= pwdata[DATA_W-1:0];
        REG_SP_PITCH:    setpoint_pitch <= pwdata[DATA_W-1:0];
        REG_GAIN_PROP:   gain_prop      <= pwdata[DATA_W-1:0];
        REG_GAIN_INTEG:  gain_integ     <= pwdata[DATA_W-1:0];
        REG_GAIN_DERIV:  gain_deriv     <= pwdata[DATA_W-1:0];
        REG_INTEG_LIMIT: integ_limit    <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SP_ROLL:     prdata = CFG_DATA_W'(unsigned'(setpoint_roll));
      REG_SP_PITCH:    prdata = CFG_DATA_W'(unsigned'(setpoint_pitch));
      REG_GAIN_PROP:   prdata = CFG_DATA_W'(gain_prop);
      REG_GAIN_INTEG:  prdata = CFG_DATA_W'(gain_integ);
      REG_GAIN_DERIV:  prdata = CFG_DATA_W'(gain_deriv);
      REG_INTEG_LIMIT: prdata = CFG_DATA_W'(integ_limit);
      default:         prdata = '0;
    endcase
  end

  // Hold off input transactions during reset and while an item runs
  assign s_tready = ~busy & ~rst;
  assign accept   = s_tvalid & s_tready;

  assign stat.div_busy  = div_busy;
  assign stat.last_axis = last_axis;
  assign stat.out_full  = m_tvalid & ~m_tready;

  rpc_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  rpc_dp #(
    .NUM_AXES (NUM_AXES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .load           (accept),
    .meas_roll      (s_tdata[15:0]),
    .meas_pitch     (s_tdata[31:16]),
    .time_step      (s_tdata[47:32]),
    .setpoint_roll  (setpoint_roll),
    .setpoint_pitch (setpoint_pitch),
    .gain_prop      (gain_prop),
    .gain_integ     (gain_integ),
    .gain_deriv     (gain_deriv),
    .integ_limit    (integ_limit),
    .ctrl           (ctrl),
    .div_busy       (div_busy),
    .last_axis      (last_axis),
    .roll_corr      (roll_corr),
    .pitch_corr     (pitch_corr)
  );

  // Hand the finished transaction to the output register
  assign fire = (ctrl.op == OP_DONE) & ~stat.out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {pitch_corr, roll_corr};
    end
  end

endmodule

`default_nettype wire

/* rtl/rpc_div.sv */
`default_nettype none

module rpc_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [rpc_pkg::DIFF_W-1:0]    num,
  input  logic        [rpc_pkg::DATA_W-1:0]    den,
  output logic                                 busy,
  output logic        [rpc_pkg::QUO_W-1:0]     quo
);
  import rpc_pkg::*;

  localparam int ITERS = QUO_W / 2;
  localparam int CNT_W = $clog2(ITERS);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] den_r;
  logic [QUO_W-1:0]  q;
  logic [CNT_W-1:0]  cnt;
  logic [DIFF_W-1:0] mag;
  logic [DATA_W:0]   r1;
  logic [DATA_W:0]   r2;
  logic              b1;
  logic              b2;
  logic [DATA_W-1:0] rem1;
  logic [DATA_W-1:0] rem2;

  // Two restoring steps per cycle
  always_comb begin
    mag  = num[DIFF_W-1] ? DIFF_W'(-num) : num;
    r1   = {rem, q[QUO_W-1]};
    b1   = (r1 >= {1'b0, den_r});
    rem1 = b1 ? DATA_W'(r1 - {1'b0, den_r}) : r1[DATA_W-1:0];
    r2   = {rem1, q[QUO_W-2]};
    b2   = (r2 >= {1'b0, den_r});
    rem2 = b2 ? DATA_W'(r2 - {1'b0, den_r}) : r2[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(ITERS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_r <= den;
      q     <= {mag, {DATA_W{1'b0}}};
    end else if (busy) begin
      rem <= rem2;
      q   <= {q[QUO_W-3:0], b1, b2};
    end
  end

  assign quo = q;

endmodule

`default_nettype wire

/* rtl/rpc_seq.sv */
`default_nettype none

module rpc_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  rpc_pkg::rpc_stat_t   stat,
  output rpc_pkg::rpc_ctrl_t   ctrl,
  output logic                 busy
);
  import rpc_pkg::*;

  localparam logic [PC_W-1:0] PC_TOP      = 4'd0;
  localparam logic [PC_W-1:0] PC_WAIT_DIV = 4'd7;
  localparam logic [PC_W-1:0] PC_DONE     = 4'd14;

  localparam rpc_ctrl_t NOP_WORD = '{op: OP_NOP, mul: MUL_NONE, acc: ACC_NONE,
                                     jmp: JMP_NEXT, target: PC_TOP};

  logic             run;
  logic [PC_W-1:0]  pc;
  rpc_ctrl_t        word;
  logic             taken;

  // Per-axis program; the divider runs alongside the multiply steps
  function automatic rpc_ctrl_t rom(input logic [PC_W-1:0] addr);
    rpc_ctrl_t w;
    w = NOP_WORD;
    unique case (addr)
      4'd0:  w.op = OP_ERR;
      4'd1:  begin w.op = OP_DIFF;     w.mul = MUL_ERR_STEP; end
      4'd2:  begin w.op = OP_DSTART;   w.acc = ACC_CLR;      end
      4'd3:  begin w.op = OP_INTSUM;   w.mul = MUL_KP_ERR;   end
      4'd4:  begin w.op = OP_INTCLAMP; w.acc = ACC_ADD12;    end
      4'd5:  w.mul = MUL_KI_INT;
      4'd6:  w.acc = ACC_ADD;
      4'd7:  begin w.jmp = JMP_DIV_BUSY; w.target = PC_WAIT_DIV; end
      4'd8:  w.op = OP_DERIV;
      4'd9:  w.mul = MUL_KD_DER;
      4'd10: w.acc = ACC_ADD12;
      4'd11: w.acc = ACC_NEG;
      4'd12: w.op = OP_RESULT;
      4'd13: begin w.op = OP_NEXTAX; w.jmp = JMP_MORE_AX;  w.target = PC_TOP;  end
      4'd14: begin w.op = OP_DONE;   w.jmp = JMP_OUT_FULL; w.target = PC_DONE; end
      default: w = NOP_WORD;
    endcase
    return w;
  endfunction

  always_comb begin
    word = rom(pc);
    case (word.jmp)
      JMP_DIV_BUSY: taken = stat.div_busy;
      JMP_MORE_AX:  taken = ~stat.last_axis;
      JMP_OUT_FULL: taken = stat.out_full;
      default:      taken = 1'b0;
    endcase
    ctrl = run ? word : NOP_WORD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      pc  <= PC_TOP;
    end else if (!run) begin
      if (start) begin
        run <= 1'b1;
        pc  <= PC_TOP;
      end
    end else begin
      pc <= taken ? word.target : pc + 1'b1;
      if (word.op == OP_DONE && !taken) begin
        run <= 1'b0;
      end
    end
  end

  assign busy = run;

endmodule

`default_nettype wire

/* rtl/rpc_dp.sv */
`default_nettype none

module rpc_dp #(
  parameter int NUM_AXES = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic signed [rpc_pkg::DATA_W-1:0]    meas_roll,
  input  logic signed [rpc_pkg::DATA_W-1:0]    meas_pitch,
  input  logic        [rpc_pkg::DATA_W-1:0]    time_step,
  input  logic signed [rpc_pkg::DATA_W-1:0]    setpoint_roll,
  input  logic signed [rpc_pkg::DATA_W-1:0]    setpoint_pitch,
  input  logic        [rpc_pkg::DATA_W-1:0]    gain_prop,
  input  logic        [rpc_pkg::DATA_W-1:0]    gain_integ,
  input  logic        [rpc_pkg::DATA_W-1:0]    gain_deriv,
  input  logic        [rpc_pkg::LIMIT_W-1:0]   integ_limit,
  input  rpc_pkg::rpc_ctrl_t                   ctrl,
  output logic                                 div_busy,
  output logic                                 last_axis,
  output logic signed [rpc_pkg::DATA_W-1:0]    roll_corr,
  output logic signed [rpc_pkg::DATA_W-1:0]    pitch_corr
);
  import rpc_pkg::*;

  localparam int AX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam logic [AX_W-1:0] LAST_AX = AX_W'(NUM_AXES - 1);
  localparam logic signed [INTEG_W-1:0] DERIV_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [INTEG_W-1:0] DERIV_MIN = 32'sh8000_0000;

  logic signed [DATA_W-1:0]  meas_roll_r;
  logic signed [DATA_W-1:0]  meas_pitch_r;
  logic        [DATA_W-1:0]  step_r;
  logic        [AX_W-1:0]    ax;
  logic signed [INTEG_W-1:0] integ_acc [NUM_AXES];
  logic signed [ERR_W-1:0]   prev_error [NUM_AXES];

  logic signed [ERR_W-1:0]   err_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [ISUM_W-1:0]  isum_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [INTEG_W-1:0] deriv_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [DATA_W-1:0]  roll_r;
  logic signed [DATA_W-1:0]  pitch_r;

  logic signed [DATA_W-1:0]  sp_sel;
  logic signed [DATA_W-1:0]  meas_sel;
  logic signed [ERR_W-1:0]   err_next;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [PROD_W-1:0]  inc;
  logic signed [ISUM_W-1:0]  lim_s;
  logic signed [ISUM_W-1:0]  clamp;
  logic        [QUO_W-1:0]   quo;
  logic signed [INTEG_W-1:0] deriv_next;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   acc_next;
  logic signed [ACC_W-1:0]   shr;
  logic signed [DATA_W-1:0]  sat;

  rpc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.op == OP_DSTART),
    .num   (diff_r),
    .den   (step_r),
    .busy  (div_busy),
    .quo   (quo)
  );

  assign last_axis = (ax == LAST_AX);

  always_comb begin
    sp_sel   = '0;
    meas_sel = '0;
    if (ax == AX_W'(0)) begin
      sp_sel   = setpoint_roll;
      meas_sel = meas_roll_r;
    end else if (ax == AX_W'(1)) begin
      sp_sel   = setpoint_pitch;
      meas_sel = meas_pitch_r;
    end
    err_next = {sp_sel[DATA_W-1], sp_sel} - {meas_sel[DATA_W-1], meas_sel};
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul)
      MUL_ERR_STEP: begin
        mul_a = err_r;
        mul_b = {{(MUL_B_W-DATA_W){1'b0}}, step_r};
      end
      MUL_KP_ERR: begin
        mul_a = {1'b0, gain_prop};
        mul_b = {{(MUL_B_W-ERR_W){err_r[ERR_W-1]}}, err_r};
      end
      MUL_KI_INT: begin
        mul_a = {1'b0, gain_integ};
        mul_b = integ_r;
      end
      MUL_KD_DER: begin
        mul_a = {1'b0, gain_deriv};
        mul_b = deriv_r;
      end
      default: ;
    endcase
    prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_comb begin
    inc   = prod_r >>> 4;
    lim_s = $signed({2'b00, integ_limit});
    if (isum_r > lim_s) begin
      clamp = lim_s;
    end else if (isum_r < -lim_s) begin
      clamp = -lim_s;
    end else begin
      clamp = isum_r;
    end

    // Truncate toward zero, saturate to 32 bits; zero step gives zero
    if (step_r == '0) begin
      deriv_next = '0;
    end else if (!diff_r[DIFF_W-1]) begin
      deriv_next = (quo > QUO_W'(32'h7FFF_FFFF)) ? DERIV_MAX : $signed(quo[INTEG_W-1:0]);
    end else begin
      deriv_next = (quo > QUO_W'(32'h8000_0000)) ? DERIV_MIN : -$signed(quo[INTEG_W-1:0]);
    end

    prod_ext = ACC_W'(prod_r);
    case (ctrl.acc)
      ACC_CLR:   acc_next = '0;
      ACC_ADD:   acc_next = acc_r + prod_ext;
      ACC_ADD12: acc_next = acc_r + (prod_ext <<< 12);
      ACC_NEG:   acc_next = -acc_r;
      default:   acc_next = acc_r;
    endcase

    shr = acc_r >>> 20;
    if (shr > ACC_W'(32767)) begin
      sat = 16'sh7FFF;
    end else if (shr < ACC_W'(-32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = shr[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      meas_roll_r  <= meas_roll;
      meas_pitch_r <= meas_pitch;
      step_r       <= time_step;
    end
    if (ctrl.mul != MUL_NONE) begin
      prod_r <= prod_next;
    end
    acc_r <= acc_next;
    unique case (ctrl.op)
      OP_ERR:    err_r   <= err_next;
      OP_DIFF:   diff_r  <= {err_r[ERR_W-1], err_r} - {prev_error[ax][ERR_W-1], prev_error[ax]};
      OP_INTSUM: isum_r  <= ISUM_W'(integ_acc[ax]) + ISUM_W'(inc);
      OP_INTCLAMP: integ_r <= INTEG_W'(clamp);
      OP_DERIV:  deriv_r <= deriv_next;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ax      <= '0;
      roll_r  <= '0;
      pitch_r <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        integ_acc[i]  <= '0;
        prev_error[i] <= '0;
      end
    end else begin
      unique case (ctrl.op)
        OP_DIFF:     prev_error[ax] <= err_r;
        OP_INTCLAMP: integ_acc[ax]  <= INTEG_W'(clamp);
        OP_RESULT: begin
          if (ax == AX_W'(0)) begin
            roll_r <= sat;
          end else if (ax == AX_W'(1)) begin
            pitch_r <= sat;
          end
        end
        OP_NEXTAX:   ax <= last_axis ? '0 : ax + 1'b1;
        default: ;
      endcase
    end
  end

  assign roll_corr  = roll_r;
  assign pitch_corr = pitch_r;

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rpc_pkg::*;

  localparam int REG_SETPOINT_ROLL  = 0;
  localparam int REG_SETPOINT_PITCH = 1;
  localparam int REG_GAIN_PROP      = 2;
  localparam int REG_GAIN_INTEG     = 3;
  localparam int REG_GAIN_DERIV     = 4;
  localparam int REG_INTEG_LIMIT    = 5;
  localparam int REG_COUNT          = 6;

  localparam int  IDLE_LIMIT   = 4000;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  DRAIN_CYCLES = 60;
  localparam int  RAND_PHASES  = 12;
  localparam int  PHASE_ITEMS  = 160;

  localparam longint INT32_LO = -(longint'(1) <<< 31);
  localparam longint INT32_HI = (longint'(1) <<< 31) - 1;

  typedef enum logic [2:0] {
    CS_KEEP, CS_PASS, CS_SAT, CS_DERIV, CS_FULL, CS_LOWLIM
  } cfg_set_e;

  typedef enum int {
    IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] step;
    cfg_set_e    cfg;
    logic        typed;
    logic [15:0] exp_roll;
    logic [15:0] exp_pitch;
  } dir_row_t;

  localparam int DIR_COUNT = 21;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    // all gains zero after reset
    '{16'h7FFF, 16'h8000, 16'hFFFF, CS_KEEP,   1'b1, 16'h0000, 16'h0000},
    '{16'h8000, 16'h7FFF, 16'h0000, CS_KEEP,   1'b1, 16'h0000, 16'h0000},
    '{16'h0000, 16'h0000, 16'h0001, CS_KEEP,   1'b1, 16'h0000, 16'h0000},
    // unity proportional gain passes the measurement through
    '{16'h7FFF, 16'h8000, 16'hFFFF, CS_PASS,   1'b1, 16'h7FFF, 16'h8000},
    '{16'h8000, 16'h7FFF, 16'h0000, CS_KEEP,   1'b1, 16'h8000, 16'h7FFF},
    '{16'h1234, 16'hFEDC, 16'h0100, CS_KEEP,   1'b1, 16'h1234, 16'hFEDC},
    // full proportional gain saturates both ways
    '{16'h7FFF, 16'h8000, 16'h0100, CS_SAT,    1'b1, 16'h7FFF, 16'h8000},
    '{16'h0001, 16'hFFFF, 16'h0100, CS_KEEP,   1'b0, 16'h0000, 16'h0000},
    // derivative only: zero step gives no derivative
    '{16'h7FFF, 16'h8000, 16'h0000, CS_DERIV,  1'b1, 16'h0000, 16'h0000},
    '{16'h8000, 16'h7FFF, 16'h0001, CS_KEEP,   1'b0, 16'h0000, 16'h0000},
    '{16'h0000, 16'h0000, 16'hFFFF, CS_KEEP,   1'b0, 16'h0000, 16'h0000},
    '{16'h0000, 16'h0000, 16'h0000, CS_KEEP,   1'b1, 16'h0000, 16'h0000},
    // all terms, wide integral limit
    '{16'h0000, 16'h0000, 16'hFFFF, CS_FULL,   1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h8000, 16'hFFFF, CS_KEEP,   1'b0, 16'h0000, 16'h0000},
    '{16'h8000, 16'h7FFF, 16'hFFFF, CS_KEEP,   1'b0, 16'h0000, 16'h0000},
    '{16'h1000, 16'hF000, 16'h0001, CS_KEEP,   1'b0, 16'h0000, 16'h0000},
    '{16'h0000, 16'h0000, 16'h0000, CS_KEEP,   1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h7FFF, 16'hFFFF, CS_KEEP,   1'b0, 16'h0000, 16'h0000},
    // limit lowered under a large stored integral
    '{16'h0100, 16'h0100, 16'h0148, CS_LOWLIM, 1'b0, 16'h0000, 16'h0000},
    '{16'h0100, 16'h0100, 16'h0148, CS_KEEP,   1'b0, 16'h0000, 16'h0000},
    '{16'h8000, 16'h8000, 16'h0000, CS_KEEP,   1'b0, 16'h0000, 16'h0000}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [47:0]           s_tdata = '0;  // meas_roll, meas_pitch, time_step
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;       // roll_corr, pitch_corr

  // tags travelling with each input transaction
  logic        s_typed = 1'b0;
  logic [31:0] s_typed_comp = '0;

  // shadow registers and compensator state
  longint sp_roll, sp_pitch, gain_p, gain_i, gain_d, integ_lim;
  longint integ_acc [2];
  longint prev_err [2];

  logic [31:0] comp_q [$];
  logic [31:0] comp_pred;
  logic [31:0] comp_want;

  int fail_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int settings_count = 0;
  int idle_cycles = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;

  roll_pitch_pid_compensator u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  function automatic void clear_shadow();
    sp_roll = 0;
    sp_pitch = 0;
    gain_p = 0;
    gain_i = 0;
    gain_d = 0;
    integ_lim = 0;
    for (int ax = 0; ax < 2; ax++) begin
      integ_acc[ax] = 0;
      prev_err[ax] = 0;
    end
  endfunction

  function automatic void write_shadow(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
    case (int'(addr >> 2))
      REG_SETPOINT_ROLL:  sp_roll = longint'($signed(data[15:0]));
      REG_SETPOINT_PITCH: sp_pitch = longint'($signed(data[15:0]));
      REG_GAIN_PROP:      gain_p = longint'(data[15:0]);
      REG_GAIN_INTEG:     gain_i = longint'(data[15:0]);
      REG_GAIN_DERIV:     gain_d = longint'(data[15:0]);
      REG_INTEG_LIMIT:    integ_lim = longint'(data[30:0]);
      default: ;
    endcase
  endfunction

  // Advance both axes by one sample and return {pitch_corr, roll_corr}.
  function automatic logic [31:0] pid_compensate(logic [15:0] roll, logic [15:0] pitch,
                                                 logic [15:0] step);
    longint meas, sp, err, integ, deriv, sum, dt;
    logic [1:0][15:0] comp;
    dt = longint'(step);
    for (int ax = 0; ax < 2; ax++) begin
      meas = (ax == 0) ? longint'($signed(roll)) : longint'($signed(pitch));
      sp = (ax == 0) ? sp_roll : sp_pitch;
      err = sp - meas;

      integ = integ_acc[ax] + ((err * dt) >>> 4);
      if (integ > integ_lim) integ = integ_lim;
      else if (integ < -integ_lim) integ = -integ_lim;
      integ_acc[ax] = integ;

      if (dt == 0) begin
        deriv = 0;
      end else begin
        deriv = ((err - prev_err[ax]) * 65536) / dt;
        if (deriv > INT32_HI) deriv = INT32_HI;
        else if (deriv < INT32_LO) deriv = INT32_LO;
      end
      prev_err[ax] = err;

      sum = gain_p * err * 4096 + gain_i * integ + gain_d * deriv * 4096;
      sum = (-sum) >>> 20;
      if (sum > 32767) sum = 32767;
      else if (sum < -32768) sum = -32768;
      comp[ax] = sum[15:0];
    end
    return comp;
  endfunction

  // Predict on every accepted input, check every accepted result.
  always @(posedge clk) begin
    if (rst) begin
      clear_shadow();
      idle_cycles <= 0;
    end else begin
      if (psel && penable && pwrite && pready) write_shadow(paddr, pwdata);
      if (s_tvalid && s_tready) begin
        comp_pred = pid_compensate(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]);
        comp_q.push_back(s_typed ? s_typed_comp : comp_pred);
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (comp_q.size() == 0) begin
          $error("result with nothing expected: roll_corr %0d pitch_corr %0d",
                 $signed(m_tdata[15:0]), $signed(m_tdata[31:16]));
          fail_count++;
        end else begin
          comp_want = comp_q.pop_front();
          if (m_tdata[15:0] !== comp_want[15:0]) begin
            $error("roll_corr: expected %0d, actual %0d",
                   $signed(comp_want[15:0]), $signed(m_tdata[15:0]));
            fail_count++;
          end
          if (m_tdata[31:16] !== comp_want[31:16]) begin
            $error("pitch_corr: expected %0d, actual %0d",
                   $signed(comp_want[31:16]), $signed(m_tdata[31:16]));
            fail_count++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (psel && penable && pwrite && pready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, comp_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic apb_write(input int idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic apb_release();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    settings_count++;
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (comp_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_set(input cfg_set_e sel);
    logic [15:0] spr, spp, kp, ki, kd;
    logic [30:0] lim;
    spr = '0;
    spp = '0;
    kp = '0;
    ki = '0;
    kd = '0;
    lim = '0;
    case (sel)
      CS_PASS:  kp = 16'd256;
      CS_SAT:   kp = 16'hFFFF;
      CS_DERIV: kd = 16'hFFFF;
      CS_FULL, CS_LOWLIM: begin
        spr = 16'h0C00;
        spp = 16'hF800;
        kp = 16'd300;
        ki = 16'd5000;
        kd = 16'd40;
        lim = (sel == CS_FULL) ? 31'h7FFFFFFF : 31'd1000;
      end
      default: ;
    endcase
    apb_write(REG_SETPOINT_ROLL, {{16{spr[15]}}, spr});
    apb_write(REG_SETPOINT_PITCH, {{16{spp[15]}}, spp});
    apb_write(REG_GAIN_PROP, {16'h0, kp});
    apb_write(REG_GAIN_INTEG, {16'h0, ki});
    apb_write(REG_GAIN_DERIV, {16'h0, kd});
    apb_write(REG_INTEG_LIMIT, {1'b0, lim});
    // writes past the last register must change nothing
    if (sel == CS_LOWLIM) begin
      apb_write(REG_COUNT, 32'hFFFFFFFF);
      apb_write(REG_COUNT + 1, 32'h00001234);
    end
    apb_release();
  endtask

  task automatic apply_random_cfg();
    logic [15:0] v16;
    logic [31:0] v;
    for (int r = 0; r < REG_COUNT; r++) begin
      case (r)
        REG_SETPOINT_ROLL, REG_SETPOINT_PITCH: begin
          case ($urandom_range(0, 3))
            0: v16 = 16'h8000;
            1: v16 = 16'h7FFF;
            2: v16 = 16'($urandom);
            default: v16 = 16'($urandom_range(0, 4000)) - 16'd2000;
          endcase
          v = {{16{v16[15]}}, v16};
        end
        REG_INTEG_LIMIT: begin
          case ($urandom_range(0, 3))
            0: v = 32'h0;
            1: v = 32'h7FFFFFFF;
            2: v = $urandom & 32'h7FFFFFFF;
            default: v = $urandom_range(0, 1 << 22);
          endcase
        end
        default: begin
          case ($urandom_range(0, 5))
            0: v = 32'h0;
            1: v = 32'hFFFF;
            2: v = {16'h0, 16'($urandom)};
            default: v = $urandom_range(0, 600);
          endcase
        end
      endcase
      apb_write(r, v);
    end
    apb_release();
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin tx_idle_pct = 53; rx_stall_pct <= 0;  end
      IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct <= 53; end
      IDLE_BOTH:     begin tx_idle_pct = 8;  rx_stall_pct <= 8;  end
      default:       begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
    endcase
  endtask

  task automatic send_item(input logic [15:0] roll, input logic [15:0] pitch,
                           input logic [15:0] step, input logic typed,
                           input logic [31:0] typed_comp);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {step, pitch, roll};
    s_typed <= typed;
    s_typed_comp <= typed_comp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Mostly samples near the setpoint at control-loop step sizes, some raw noise.
  task automatic send_random();
    logic [15:0] r, p, dt;
    if ($urandom_range(0, 3) != 0) begin
      r = 16'(sp_roll) + 16'($urandom_range(0, 1600)) - 16'd800;
      p = 16'(sp_pitch) + 16'($urandom_range(0, 1600)) - 16'd800;
      dt = 16'($urandom_range(1, 1500));
    end else begin
      r = 16'($urandom);
      p = 16'($urandom);
      case ($urandom_range(0, 3))
        0: dt = 16'h0000;
        1: dt = 16'hFFFF;
        2: dt = 16'h0001;
        default: dt = 16'($urandom);
      endcase
    end
    send_item(r, p, dt, 1'b0, 32'h0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(IDLE_NONE);
    for (int i = 0; i < DIR_COUNT; i++) begin
      if (DIR_ROWS[i].cfg != CS_KEEP) begin
        wait_idle();
        apply_set(DIR_ROWS[i].cfg);
      end
      send_item(DIR_ROWS[i].roll, DIR_ROWS[i].pitch, DIR_ROWS[i].step, DIR_ROWS[i].typed,
                {DIR_ROWS[i].exp_pitch, DIR_ROWS[i].exp_roll});
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      apply_random_cfg();
      set_idling(idle_mode_e'(ph % 4));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // back up the block behind a stuck receiver
        if (ph == 4 && k == 40) hold_go <= 1'b1;
        // let the pipeline run dry mid-phase
        if (ph == 5 && k == 80) wait_idle();
        send_random();
      end
    end

    s_tvalid <= 1'b0;
    rx_stall_pct <= 0;
    @(posedge clk);
    while (comp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d directed) across %0d register settings and four idle mixes,",
             items_sent, DIR_COUNT, settings_count);
    $display("including a %0d-cycle receiver hold-off; %0d results checked, %0d mismatches.",
             HOLD_CYCLES, results_seen, fail_count);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
